// ===== rtl/core/ucrw_pkg.sv =====
// Shared types, constants and defaults for the UART command responder and watchdog.
`default_nettype none

package ucrw_pkg;

    // Default sizes of the receive frame, the reply frame and the header search.
    localparam int unsigned FRAME_BYTES_DEF = 30;
    localparam int unsigned REPLY_BYTES_DEF = 20;
    localparam int unsigned SCAN_LIMIT_DEF  = 10;

    // Number of time-of-day bytes carried in a frame and in a reply.
    localparam int unsigned TIME_BYTES = 6;
    localparam int unsigned TIME_SEL_W = $clog2(TIME_BYTES);

    // Depth of the job queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Link framing bytes and command codes.
    localparam logic [7:0] HDR_BYTE     = 8'hC0;
    localparam logic [7:0] END_BYTE     = 8'hC1;
    localparam logic [7:0] CMD_TIME_A   = 8'hE0;
    localparam logic [7:0] CMD_SET_TIME = 8'hEA;
    localparam logic [7:0] CMD_TIME_B   = 8'hEB;

    // Input word operation codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register map and reset values.
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam logic [0:0]  REG_WDOG_LIMIT = 1'b0;
    localparam logic [0:0]  REG_POWER_OFF  = 1'b1;
    localparam logic [15:0] WDOG_LIMIT_RST = 16'd600;
    localparam logic [7:0]  POWER_OFF_RST  = 8'd10;
    localparam logic [15:0] WDOG_MAX       = 16'hFFFF;

    // Receiver framing state.
    typedef enum logic {
        RX_HUNT,
        RX_FRAME
    } t_rx_mode;

    // Input word.
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       partner_power;
        logic [7:0] restarts;
    } t_out_word;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] watchdog_limit;
        logic [7:0]  power_off_seconds;
    } t_cfg;

    // One job for the back part: either a reply frame or a single status word.
    typedef struct packed {
        logic                         is_reply;
        logic [7:0]                   cmd;
        logic [TIME_BYTES-1:0][7:0]   tod;
        logic                         partner_power;
        logic [7:0]                   restarts;
    } t_job;

    // Front part to queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_push;

    // Queue head to back part.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

endpackage

`default_nettype wire

// ===== rtl/core/ucrw_front.sv =====
// Front part: accepts input words, tracks framing, the watchdog and partner power.
`default_nettype none

module ucrw_front
    import ucrw_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int unsigned SCAN_LIMIT  = SCAN_LIMIT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_data,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_q_full,
    output t_q_push       o_push
);

    localparam int unsigned IDX_W  = $clog2(FRAME_BYTES + 1);
    localparam int unsigned SCAN_W = $clog2(SCAN_LIMIT + 1);

    t_rx_mode                   r_mode, n_mode;
    logic [SCAN_W-1:0]          r_scan, n_scan;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [7:0]                 r_cmd, n_cmd;
    logic [TIME_BYTES-1:0][7:0] r_pend, n_pend;
    logic [TIME_BYTES-1:0][7:0] r_tod, n_tod;
    logic [15:0]                r_wdog, n_wdog;
    logic [7:0]                 r_restarts, n_restarts;
    logic [7:0]                 r_off, n_off;
    logic                       r_power, n_power;

    logic                  accept;
    logic                  is_byte;
    logic                  is_tick;
    logic                  is_hdr;
    logic [SCAN_W-1:0]     scan_inc;
    logic                  scan_done;
    logic [IDX_W-1:0]      frame_pos;
    logic                  frame_done;
    logic [TIME_SEL_W-1:0] pend_sel;
    logic                  cmd_time;
    logic                  cmd_set;
    logic [15:0]           wdog_inc;
    logic [7:0]            off_dec;

    // A word is taken whenever the queue has room.
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_byte    = accept && (i_in_data.op == OP_BYTE) && r_power;
    assign is_tick    = accept && (i_in_data.op == OP_TICK);

    // Framing helpers.
    assign is_hdr     = (i_in_data.rx_byte == HDR_BYTE);
    assign scan_inc   = r_scan + SCAN_W'(1);
    assign scan_done  = (scan_inc >= SCAN_W'(SCAN_LIMIT));
    assign frame_pos  = r_idx + IDX_W'(1);
    assign frame_done = (r_mode == RX_FRAME) && (frame_pos >= IDX_W'(FRAME_BYTES));
    assign pend_sel   = TIME_SEL_W'(frame_pos - IDX_W'(2));
    assign cmd_time   = (r_cmd == CMD_TIME_A) || (r_cmd == CMD_TIME_B);
    assign cmd_set    = (r_cmd == CMD_SET_TIME);

    // Watchdog and power-off helpers.
    assign wdog_inc = (r_wdog == WDOG_MAX) ? r_wdog : r_wdog + 16'd1;
    assign off_dec  = (r_off != 8'd0) ? r_off - 8'd1 : r_off;

    // Next framing state.
    always_comb begin
        n_mode = r_mode;
        if (is_byte) begin
            unique case (r_mode)
                RX_HUNT: begin
                    if (is_hdr || scan_done) begin
                        n_mode = RX_FRAME;
                    end
                end
                RX_FRAME: begin
                    if (frame_done) begin
                        n_mode = RX_HUNT;
                    end
                end
                default: n_mode = RX_HUNT;
            endcase
        end
    end

    // Frame collection, command action, watchdog and power control.
    always_comb begin
        n_scan     = r_scan;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_pend     = r_pend;
        n_tod      = r_tod;
        n_wdog     = r_wdog;
        n_restarts = r_restarts;
        n_off      = r_off;
        n_power    = r_power;
        if (is_byte) begin
            unique case (r_mode)
                RX_HUNT: begin
                    if (!is_hdr) begin
                        n_scan = scan_inc;
                    end
                    if (is_hdr || scan_done) begin
                        n_idx = '0;
                    end
                end
                RX_FRAME: begin
                    if (frame_pos == IDX_W'(1)) begin
                        n_cmd = i_in_data.rx_byte;
                    end
                    if ((frame_pos >= IDX_W'(2)) && (frame_pos <= IDX_W'(TIME_BYTES + 1))) begin
                        n_pend[pend_sel] = i_in_data.rx_byte;
                    end
                    n_idx = frame_pos;
                    if (frame_done) begin
                        n_idx  = '0;
                        n_scan = '0;
                        if (cmd_time) begin
                            n_wdog = '0;
                        end else if (cmd_set) begin
                            n_tod = r_pend;
                        end
                    end
                end
                default: n_idx = '0;
            endcase
        end else if (is_tick) begin
            if (!r_power) begin
                n_off = off_dec;
                if (off_dec == 8'd0) begin
                    n_power = 1'b1;
                end
            end else begin
                n_wdog = wdog_inc;
                if (wdog_inc >= i_cfg.watchdog_limit) begin
                    n_wdog     = '0;
                    n_restarts = r_restarts + 8'd1;
                    n_off      = i_cfg.power_off_seconds;
                    if (i_cfg.power_off_seconds != 8'd0) begin
                        n_power = 1'b0;
                    end
                end
            end
        end
    end

    // Job handed to the back part for every accepted word.
    always_comb begin
        o_push.valid             = accept;
        o_push.job.is_reply      = is_byte && frame_done && (cmd_time || cmd_set);
        o_push.job.cmd           = r_cmd;
        o_push.job.tod           = cmd_time ? r_tod : '0;
        o_push.job.partner_power = n_power;
        o_push.job.restarts      = n_restarts;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= RX_HUNT;
            r_scan     <= '0;
            r_idx      <= '0;
            r_tod      <= '0;
            r_wdog     <= '0;
            r_restarts <= '0;
            r_off      <= '0;
            r_power    <= 1'b1;
        end else begin
            r_mode     <= n_mode;
            r_scan     <= n_scan;
            r_idx      <= n_idx;
            r_tod      <= n_tod;
            r_wdog     <= n_wdog;
            r_restarts <= n_restarts;
            r_off      <= n_off;
            r_power    <= n_power;
        end
    end

    // Frame payload, always written before it is used.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ucrw_queue.sv =====
// Short job queue between the front and back parts.
`default_nettype none

module ucrw_queue
    import ucrw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_push i_push,
    input  wire logic    i_pop,
    output logic         o_full,
    output t_q_head      o_head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ucrw_back.sv =====
// Back part: turns queued jobs into reply bytes or status words on the output register.
`default_nettype none

module ucrw_back
    import ucrw_pkg::*;
#(
    parameter int unsigned REPLY_BYTES = REPLY_BYTES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_out_word    o_out_data
);

    localparam int unsigned RIDX_W = $clog2(REPLY_BYTES);

    logic [RIDX_W-1:0]     r_idx, n_idx;
    logic                  r_out_valid;
    t_out_word             r_out_data;
    t_out_word             word;
    logic                  load;
    logic [TIME_SEL_W-1:0] tod_sel;

    assign tod_sel = TIME_SEL_W'(r_idx - RIDX_W'(2));

    // Build the word for the current position of the head job.
    always_comb begin
        word.partner_power = i_head.job.partner_power;
        word.restarts      = i_head.job.restarts;
        word.tx_valid      = 1'b0;
        word.tx_byte       = 8'h00;
        word.last          = 1'b1;
        if (i_head.job.is_reply) begin
            word.tx_valid = 1'b1;
            word.last     = (r_idx == RIDX_W'(REPLY_BYTES - 1));
            if (r_idx == RIDX_W'(0)) begin
                word.tx_byte = HDR_BYTE;
            end else if (r_idx == RIDX_W'(1)) begin
                word.tx_byte = i_head.job.cmd;
            end else if (r_idx == RIDX_W'(REPLY_BYTES - 1)) begin
                word.tx_byte = END_BYTE;
            end else if (r_idx <= RIDX_W'(TIME_BYTES + 1)) begin
                word.tx_byte = i_head.job.tod[tod_sel];
            end
        end
    end

    // The output register loads when empty or being drained.
    assign load  = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop = load && word.last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = word.last ? '0 : r_idx + RIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/uart_command_responder_watchdog_core.sv =====
// Top level of the UART command responder and watchdog.
//
// Input channel: each word is either a received link byte (op 0) or a one-second tick (op 1).
// Output channel: each word carries a reply byte with tx_valid set, or one status word with
// tx_valid clear; last marks the final word caused by an input word, and partner_power and
// restarts show the state after that input.
// A completed frame with a time or set-time command gives a reply of REPLY_BYTES words; every
// other input gives exactly one status word.
// The first output word passes through the job queue and then the output register.
// Throughput: one input word per cycle while the two-entry job queue has room; a reply of
// REPLY_BYTES bytes leaves the output register one byte per cycle when the receiver is ready.
// When the receiver stalls, the output register holds its word, the queue fills, and the
// input ready drops once the queue is full.
// Reset (synchronous, active low) clears framing, the watchdog, the restart count and the
// time of day, powers the partner on and loads the default register values.
// Registers on the APB port: watchdog_limit at 0x0, power_off_seconds at 0x4; write only
// while the block is idle.
`default_nettype none

module uart_command_responder_watchdog_core
    import ucrw_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int unsigned REPLY_BYTES = REPLY_BYTES_DEF,
    parameter int unsigned SCAN_LIMIT  = SCAN_LIMIT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_cfg       r_cfg;
    logic [0:0] reg_sel;
    logic       cfg_wr;
    t_q_push    q_push;
    t_q_head    q_head;
    logic       q_full;
    logic       q_pop;

    // Configuration register port.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.watchdog_limit    <= WDOG_LIMIT_RST;
            r_cfg.power_off_seconds <= POWER_OFF_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_WDOG_LIMIT: r_cfg.watchdog_limit    <= pwdata[15:0];
                REG_POWER_OFF:  r_cfg.power_off_seconds <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_WDOG_LIMIT: prdata = {16'd0, r_cfg.watchdog_limit};
            REG_POWER_OFF:  prdata = {24'd0, r_cfg.power_off_seconds};
            default:        prdata = '0;
        endcase
    end

    // Front part: framing, watchdog and power control.
    ucrw_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .SCAN_LIMIT  (SCAN_LIMIT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_push     (q_push)
    );

    // Job queue.
    ucrw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // Back part: reply and status output.
    ucrw_back #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== test/tb_uart_command_responder_watchdog_core.sv =====
// Self-checking testbench for the UART command responder and watchdog core.
`timescale 1ns / 100ps

module tb_uart_command_responder_watchdog_core
    import ucrw_pkg::*;
();

    localparam int CYCLE_LIMIT = 500000;

    typedef enum {SINK_FREE, SINK_CHOPPY, SINK_LONG} t_sink_mode;

    // Block ports; the inputs are driven to known values from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Predicted state of the responder and its registers.
    t_rx_mode    hunt_state = RX_HUNT;
    logic [3:0]  skipped_bytes = '0;
    logic [4:0]  frame_pos = '0;
    logic [7:0]  frame_cmd = '0;
    logic [5:0][7:0] frame_time = '0;
    logic [5:0][7:0] time_of_day = '0;
    logic [15:0] idle_ticks = '0;
    logic [7:0]  restart_total = '0;
    logic [7:0]  off_ticks_left = '0;
    logic        partner_on = 1'b1;
    logic [15:0] limit_reg = WDOG_LIMIT_RST;
    logic [7:0]  off_reg = POWER_OFF_RST;

    // Output words still owed by the block, oldest first.
    t_out_word due_words[$];

    int         error_count = 0;
    int         words_counted = 0;
    int         burst_left = 0;
    int         cmd_turn = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    t_sink_mode sink_mode = SINK_FREE;
    logic [7:0] sink_phase = '0;

    uart_command_responder_watchdog_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stop the run with an error once the cycle counter reaches its limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver changes its stall habit each time its 8-bit phase counter wraps: free running,
    // short random stalls, or long stalls.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (sink_mode != SINK_FREE && $urandom_range(0, 3) == 0) begin
            stall_left <= (sink_mode == SINK_LONG) ? $urandom_range(3, 16) : $urandom_range(0, 1);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
        sink_phase <= sink_phase + 8'd1;
        if (sink_phase == 8'd0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 2));
        end
    end

    // Queue one predicted output word carrying the current status.
    task automatic push_result(input logic valid, input logic [7:0] data, input logic last);
        t_out_word r;
        r.tx_valid      = valid;
        r.tx_byte       = data;
        r.last          = last;
        r.partner_power = partner_on;
        r.restarts      = restart_total;
        due_words.push_back(r);
    endtask

    // A reply frame: header, command, optional time of day, zeros, trailer.
    task automatic queue_reply(input logic with_time);
        logic [7:0] b;
        for (int i = 0; i < REPLY_BYTES_DEF; i++) begin
            b = 8'h00;
            if (i == 0) begin
                b = HDR_BYTE;
            end else if (i == 1) begin
                b = frame_cmd;
            end else if (i == REPLY_BYTES_DEF - 1) begin
                b = END_BYTE;
            end else if (with_time && i >= 2 && i <= 7) begin
                b = time_of_day[i - 2];
            end
            push_result(1'b1, b, i == REPLY_BYTES_DEF - 1);
        end
    endtask

    // Header search and frame collection for one link byte taken while powered.
    task automatic take_link_byte(input logic [7:0] b, output logic replied);
        logic [4:0] pos;
        replied = 1'b0;
        if (hunt_state == RX_HUNT) begin
            if (b == HDR_BYTE) begin
                hunt_state = RX_FRAME;
                frame_pos  = '0;
            end else begin
                skipped_bytes = skipped_bytes + 4'd1;
                if (skipped_bytes >= SCAN_LIMIT_DEF) begin
                    hunt_state = RX_FRAME;
                    frame_pos  = '0;
                end
            end
        end else begin
            pos = frame_pos + 5'd1;
            if (pos == 5'd1) begin
                frame_cmd = b;
            end else if (pos >= 5'd2 && pos <= 5'd7) begin
                frame_time[pos - 2] = b;
            end
            frame_pos = pos;
            if (frame_pos >= FRAME_BYTES_DEF) begin
                hunt_state    = RX_HUNT;
                skipped_bytes = '0;
                frame_pos     = '0;
                if (frame_cmd == CMD_TIME_A || frame_cmd == CMD_TIME_B) begin
                    idle_ticks = '0;
                    queue_reply(1'b1);
                    replied = 1'b1;
                end else if (frame_cmd == CMD_SET_TIME) begin
                    queue_reply(1'b0);
                    time_of_day = frame_time;
                    replied = 1'b1;
                end
            end
        end
    endtask

    // One-second tick: count down a power cut, or run the watchdog.
    task automatic count_tick();
        if (!partner_on) begin
            if (off_ticks_left != 0) begin
                off_ticks_left = off_ticks_left - 8'd1;
            end
            if (off_ticks_left == 0) begin
                partner_on = 1'b1;
            end
        end else begin
            if (idle_ticks != WDOG_MAX) begin
                idle_ticks = idle_ticks + 16'd1;
            end
            if (idle_ticks >= limit_reg) begin
                idle_ticks     = '0;
                restart_total  = restart_total + 8'd1;
                off_ticks_left = off_reg;
                if (off_ticks_left != 0) begin
                    partner_on = 1'b0;
                end
            end
        end
    endtask

    // Work out every output word that one accepted input word causes.
    task automatic advance_responder(input t_in_word w);
        logic replied;
        replied = 1'b0;
        if (w.op == OP_TICK) begin
            count_tick();
        end else if (partner_on) begin
            take_link_byte(w.rx_byte, replied);
        end
        if (!replied) begin
            push_result(1'b0, 8'h00, 1'b1);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check each output word against the oldest prediction.
    task automatic check_out_word(input t_out_word got);
        t_out_word want;
        if (due_words.size() == 0) begin
            $display("%0t: output word with none expected, expected nothing, actual %h",
                     $time, got);
            error_count++;
        end else begin
            want = due_words.pop_front();
            compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("last", 8'(want.last), 8'(got.last));
            compare_field("partner_power", 8'(want.partner_power), 8'(got.partner_power));
            compare_field("restarts", want.restarts, got.restarts);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_out_word(o_out_data);
        end
    end

    // Between bursts the sender may drop valid.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Offer one word and hold it until it is taken.
    task automatic send_word(input logic op, input logic [7:0] b);
        t_in_word w;
        w.op      = op;
        w.rx_byte = b;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_TICK || partner_on) begin
            words_counted++;
        end
        advance_responder(w);
        pace_sender();
    endtask

    // Stop sending and let every owed output word arrive.
    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_words.size() != 0);
    endtask

    // Register write over the configuration port, only with the block idle.
    task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
        wait_for_replies();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WDOG_LIMIT: limit_reg = value[15:0];
            REG_POWER_OFF:  off_reg = value[7:0];
        endcase
    endtask

    function automatic logic [7:0] pick_noise_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == HDR_BYTE);
        return b;
    endfunction

    // Commands rotate through both time requests, set-time and an unknown code.
    function automatic logic [7:0] next_cmd();
        logic [7:0] c;
        cmd_turn++;
        case (cmd_turn % 4)
            0: c = CMD_TIME_A;
            1: c = CMD_TIME_B;
            2: c = CMD_SET_TIME;
            default: begin
                do c = 8'($urandom);
                while (c == CMD_TIME_A || c == CMD_TIME_B || c == CMD_SET_TIME);
            end
        endcase
        return c;
    endfunction

    // Frame body: command, then random bytes, with the odd tick mixed in.
    task automatic send_frame(input logic [7:0] cmd, input int body_len);
        logic [7:0] b;
        for (int pos = 1; pos <= body_len; pos++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_word(OP_TICK, 8'($urandom));
            end
            b = (pos == 1) ? cmd : 8'($urandom);
            send_word(OP_BYTE, b);
        end
    endtask

    // Mostly well-formed frames with random content, some broken ones and noise.
    task automatic run_random_traffic(input int n_items);
        int stop_at;
        int kind;
        stop_at = words_counted + n_items;
        while (words_counted < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                repeat ($urandom_range(0, 3)) send_word(OP_BYTE, pick_noise_byte());
                send_word(OP_BYTE, HDR_BYTE);
                send_frame(next_cmd(), FRAME_BYTES_DEF);
            end else if (kind < 17) begin
                repeat ($urandom_range(SCAN_LIMIT_DEF, SCAN_LIMIT_DEF + 2)) begin
                    send_word(OP_BYTE, pick_noise_byte());
                end
                send_frame(next_cmd(), $urandom_range(0, FRAME_BYTES_DEF));
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_word(1'($urandom_range(0, 1)), 8'($urandom));
                end
            end
        end
    endtask

    // Ten non-header bytes after reset end the header search.
    task automatic test_link_noise();
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, END_BYTE);
        send_word(OP_BYTE, 8'h7F);
        send_word(OP_BYTE, 8'h80);
        send_word(OP_BYTE, CMD_TIME_A);
        send_word(OP_BYTE, CMD_SET_TIME);
        send_word(OP_BYTE, CMD_TIME_B);
        send_word(OP_BYTE, 8'h01);
        send_word(OP_BYTE, 8'hFE);
    endtask

    // Watchdog expiry, a byte ignored while the partner is off, power return,
    // and a restart that keeps power on.
    task automatic test_watchdog_restart();
        write_register(REG_WDOG_LIMIT, 32'd2);
        write_register(REG_POWER_OFF, 32'd2);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'hFF);
        send_word(OP_BYTE, HDR_BYTE);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'h55);
        write_register(REG_POWER_OFF, 32'd0);
        send_word(OP_TICK, 8'hAA);
        send_word(OP_TICK, 8'h00);
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_random_traffic();
        write_register(REG_WDOG_LIMIT, 32'd65535);
        write_register(REG_POWER_OFF, 32'd255);
        run_random_traffic(70);
        write_register(REG_WDOG_LIMIT, 32'd9);
        write_register(REG_POWER_OFF, 32'd3);
        run_random_traffic(60);
        write_register(REG_WDOG_LIMIT, 32'd1);
        write_register(REG_POWER_OFF, 32'd0);
        run_random_traffic(40);
        write_register(REG_WDOG_LIMIT, 32'd30);
        write_register(REG_POWER_OFF, 32'd1);
        run_random_traffic(35);
        // Let the reply path run dry mid-phase before carrying on.
        wait_for_replies();
        run_random_traffic(30);
    endtask

    // A long power cut, with stray bytes that must be ignored.
    task automatic test_long_power_off();
        write_register(REG_WDOG_LIMIT, 32'd1);
        write_register(REG_POWER_OFF, 32'd24);
        send_word(OP_TICK, 8'($urandom));
        send_word(OP_TICK, 8'($urandom));
        while (!partner_on) begin
            if ($urandom_range(0, 7) == 0) begin
                send_word(OP_BYTE, 8'($urandom));
            end else begin
                send_word(OP_TICK, 8'($urandom));
            end
        end
    endtask

    // A restart on every tick while the power stays on.
    task automatic test_restart_run();
        write_register(REG_WDOG_LIMIT, 32'd1);
        write_register(REG_POWER_OFF, 32'd0);
        repeat (20) send_word(OP_TICK, 8'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_link_noise();
        test_watchdog_restart();
        test_random_traffic();
        test_long_power_off();
        test_restart_run();
        wait_for_replies();
        repeat (2 * REPLY_BYTES_DEF) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
